/* rtl/rtch_pkg.sv */
// Shared types, register codes and constants for the ray/triangle closest-hit core.
package rtch_pkg;

   // Default geometry of the fixed-point coordinates
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Register file layout
   localparam int CSR_INDEX_W = 3;
   localparam int EPS_W       = 32;
   localparam int DIST_W      = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5,
      CSR_DET_EPS  = 3'd6,
      CSR_MAX_DIST = 3'd7
   } csr_index_type;

   localparam logic [EPS_W-1:0]  EPS_RST      = 32'd42950;
   localparam logic [DIST_W-1:0] MAX_DIST_RST = 31'd6553600;
   localparam logic [DIST_W-1:0] DIST_SAT     = '1;

   // Multiply-accumulate groups of the back end, in issue order
   typedef enum logic [2:0] {
      GRP_H,
      GRP_Q,
      GRP_A,
      GRP_U,
      GRP_V,
      GRP_T
   } grp_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_FIX,
      ST_CHECK,
      ST_DIVSAT,
      ST_DIV,
      ST_RES
   } state_type;

   // Next vector component, wrapping after z
   function automatic logic [1:0] next3(input logic [1:0] k);
      logic [1:0] r;
      case (k)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/rtch_queue.sv */
// Two-entry queue that decouples the triangle front end from the back end.
module rtch_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

/* rtl/rtch_front.sv */
// Front end: accepts triangles and forms the edge and origin-offset vectors.
module rtch_front
   import rtch_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int REQ_W      = ((9 * COORD_BITS + 7) / 8) * 8,
   parameter int ENT_W      = 9 * (COORD_BITS + 1) + 1
) (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_W-1:0]        req_tdata,
   input  logic                    req_tuser,
   input  logic [3*COORD_BITS-1:0] origin,
   output logic                    ent_valid,
   input  logic                    ent_ready,
   output logic [ENT_W-1:0]        ent_data
);

   localparam int CW = COORD_BITS;
   localparam int EW = CW + 1;

   // Form e1 = v1 - v0, e2 = v2 - v0, s = origin - v0 per component
   for (genvar i = 0; i < 3; i++) begin : g_vec
      logic [CW-1:0] v0, v1, v2, org;
      assign v0  = req_tdata[i*CW +: CW];
      assign v1  = req_tdata[(3+i)*CW +: CW];
      assign v2  = req_tdata[(6+i)*CW +: CW];
      assign org = origin[i*CW +: CW];
      assign ent_data[i*EW +: EW]     = {v1[CW-1], v1} - {v0[CW-1], v0};
      assign ent_data[(3+i)*EW +: EW] = {v2[CW-1], v2} - {v0[CW-1], v0};
      assign ent_data[(6+i)*EW +: EW] = {org[CW-1], org} - {v0[CW-1], v0};
   end

   assign ent_data[9*EW] = req_tuser;
   assign ent_valid      = req_tvalid;
   assign req_tready     = ent_ready;

endmodule

/* rtl/rtch_back.sv */
// Back end: shared multiply-accumulate sequencer, hit tests and bit-serial distance divide.
module rtch_back
   import rtch_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ENT_W      = 9 * (COORD_BITS + 1) + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ent_valid,
   output logic                    ent_ready,
   input  logic [ENT_W-1:0]        ent_data,
   input  logic [3*COORD_BITS-1:0] dir,
   input  logic [EPS_W-1:0]        det_eps,
   input  logic [DIST_W-1:0]       max_dist,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    out_hit,
   output logic [DIST_W-1:0]       out_dist,
   output logic [DIST_W-1:0]       out_best
);

   localparam int CW = COORD_BITS;
   localparam int EW = CW + 1;          // edge / offset width
   localparam int HW = 2 * EW + 1;      // cross product width
   localparam int LW = EW + 1;          // low slice of a cross product
   localparam int MW = LW + 1;          // second multiplier operand
   localparam int PW = EW + MW;         // product width
   localparam int DW = EW + HW + 2;     // dot product width
   localparam int RW = DW + 32;         // divider width

   state_type state_ff, state_in;

   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [EW-1:0] s_ff  [3];
   logic signed [EW-1:0] dir_e [3];
   logic signed [HW-1:0] h_ff  [3];
   logic signed [HW-1:0] q_ff  [3];
   logic signed [DW-1:0] acc_ff, a_ff, un_ff, vn_ff, tn_ff;
   grp_type              grp_ff;
   logic [1:0]           idx_ff;
   logic                 part_ff;
   logic [DIST_W-1:0]    best_ff, tq_ff;
   logic [RW-1:0]        rem_ff, den_ff;
   logic [4:0]           bit_ff;
   logic                 out_valid_ff, out_hit_ff;
   logic [DIST_W-1:0]    out_dist_ff, out_best_ff;

   logic [1:0]           j1, j2;
   logic signed [EW-1:0] op_a;
   logic signed [MW-1:0] op_b;
   logic [HW-1:0]        wsel;
   logic                 neg, hi, wr, is_dot, last_step;
   logic signed [PW-1:0] prod;
   logic signed [DW-1:0] term, sum;
   logic                 miss, div_ge, out_free, hit;
   logic signed [DW:0]   uv_sum;

   for (genvar i = 0; i < 3; i++) begin : g_dir
      assign dir_e[i] = {dir[i*CW + CW - 1], dir[i*CW +: CW]};
   end

   // Select multiplier operands for the current step
   always_comb begin
      j1     = next3(idx_ff);
      j2     = next3(j1);
      op_a   = '0;
      wsel   = '0;
      neg    = 1'b0;
      is_dot = 1'b0;
      wr     = part_ff;
      case (grp_ff)
         GRP_H: begin
            op_a = part_ff ? dir_e[j2] : dir_e[j1];
            wsel = HW'(part_ff ? e2_ff[j1] : e2_ff[j2]);
            neg  = part_ff;
         end
         GRP_Q: begin
            op_a = part_ff ? s_ff[j2] : s_ff[j1];
            wsel = HW'(part_ff ? e1_ff[j1] : e1_ff[j2]);
            neg  = part_ff;
         end
         GRP_A: begin
            op_a = e1_ff[idx_ff]; wsel = h_ff[idx_ff]; is_dot = 1'b1;
         end
         GRP_U: begin
            op_a = s_ff[idx_ff]; wsel = h_ff[idx_ff]; is_dot = 1'b1;
         end
         GRP_V: begin
            op_a = dir_e[idx_ff]; wsel = q_ff[idx_ff]; is_dot = 1'b1;
         end
         GRP_T: begin
            op_a = e2_ff[idx_ff]; wsel = q_ff[idx_ff]; is_dot = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
      hi = is_dot && part_ff;
      if (is_dot) begin
         wr   = part_ff && (idx_ff == 2'd2);
         op_b = part_ff ? MW'($signed(wsel[HW-1:LW])) : $signed({1'b0, wsel[LW-1:0]});
      end else begin
         op_b = MW'($signed(wsel[EW-1:0]));
      end
      last_step = wr && (grp_ff == GRP_T);
   end

   assign prod = op_a * op_b;
   assign term = hi ? (DW'(prod) <<< LW) : DW'(prod);
   assign sum  = neg ? (acc_ff - term) : (acc_ff + term);

   // Hit tests on the sign-corrected numerators
   assign uv_sum = (DW+1)'(un_ff) + (DW+1)'(vn_ff);
   assign miss = ($unsigned(a_ff) < DW'({det_eps, {FRAC_BITS{1'b0}}}))
              || (a_ff == '0)
              || un_ff[DW-1] || (un_ff > a_ff)
              || vn_ff[DW-1] || (uv_sum > (DW+1)'(a_ff))
              || tn_ff[DW-1] || (tn_ff == '0);
   assign div_ge   = (rem_ff >= den_ff);
   assign out_free = !out_valid_ff || out_ready;
   assign hit      = (tq_ff != '0) && (tq_ff < best_ff);
   assign ent_ready = (state_ff == ST_IDLE);

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (ent_valid) state_in = ST_MAC;
         ST_MAC:    if (last_step) state_in = ST_FIX;
         ST_FIX:    state_in = ST_CHECK;
         ST_CHECK:  state_in = miss ? ST_RES : ST_DIVSAT;
         ST_DIVSAT: state_in = div_ge ? ST_RES : ST_DIV;
         ST_DIV:    if (bit_ff == 5'd0) state_in = ST_RES;
         ST_RES:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (ent_valid) begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= ent_data[i*EW +: EW];
                  e2_ff[i] <= ent_data[(3+i)*EW +: EW];
                  s_ff[i]  <= ent_data[(6+i)*EW +: EW];
               end
               acc_ff  <= '0;
               grp_ff  <= GRP_H;
               idx_ff  <= 2'd0;
               part_ff <= 1'b0;
            end
         end
         ST_MAC: begin
            acc_ff  <= wr ? '0 : sum;
            part_ff <= ~part_ff;
            if (part_ff) begin
               if (idx_ff == 2'd2) begin
                  idx_ff <= 2'd0;
                  if (grp_ff != GRP_T) grp_ff <= grp_type'(grp_ff + 3'd1);
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            if (wr) begin
               case (grp_ff)
                  GRP_H:   h_ff[idx_ff] <= HW'(sum);
                  GRP_Q:   q_ff[idx_ff] <= HW'(sum);
                  GRP_A:   a_ff  <= sum;
                  GRP_U:   un_ff <= sum;
                  GRP_V:   vn_ff <= sum;
                  default: tn_ff <= sum;
               endcase
            end
         end
         ST_FIX: begin
            // Make the determinant positive, negating the numerators with it
            if (a_ff[DW-1]) begin
               a_ff  <= -a_ff;
               un_ff <= -un_ff;
               vn_ff <= -vn_ff;
               tn_ff <= -tn_ff;
            end
         end
         ST_CHECK: begin
            tq_ff  <= '0;
            rem_ff <= RW'($unsigned(tn_ff)) << FRAC_BITS;
            den_ff <= RW'($unsigned(a_ff)) << 31;
         end
         ST_DIVSAT: begin
            if (div_ge) tq_ff <= DIST_SAT;
            den_ff <= den_ff >> 1;
            bit_ff <= 5'd30;
         end
         ST_DIV: begin
            if (div_ge) begin
               rem_ff        <= rem_ff - den_ff;
               tq_ff[bit_ff] <= 1'b1;
            end
            den_ff <= den_ff >> 1;
            bit_ff <= bit_ff - 5'd1;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   // Best distance and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= MAX_DIST_RST;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && ent_valid && ent_data[9*EW]) best_ff <= max_dist;
         if (state_ff == ST_RES && out_free) begin
            out_valid_ff <= 1'b1;
            out_hit_ff   <= hit;
            out_dist_ff  <= hit ? tq_ff : '0;
            out_best_ff  <= hit ? tq_ff : best_ff;
            if (hit) best_ff <= tq_ff;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = out_hit_ff;
   assign out_dist  = out_dist_ff;
   assign out_best  = out_best_ff;

endmodule

/* rtl/ray_triangle_closest_hit_core.sv */
// Top level of the ray/triangle closest-hit core: register file, front end, queue, back end.
//
// The ray is set once through the csr_ write channel; triangles then stream in on req_ and
// one result per triangle leaves on rsp_. In the back end each triangle is taken from the
// queue, then runs on the single shared multiply-accumulate unit (cross products, then dot
// products in two halves each), goes through sign fix and hit tests, and, for a triangle
// that passes the tests, through the one-bit-per-cycle distance divider, and then loads the
// result register, waiting while an earlier result still waits there. The front end and a
// two-entry queue take the next triangles while the back end works, and a finished result
// waits in its own register.
module ray_triangle_closest_hit_core
   import rtch_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int REQ_W      = ((9 * COORD_BITS + 7) / 8) * 8,
   parameter int CSR_W      = (COORD_BITS > EPS_W) ? COORD_BITS : EPS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_W-1:0]       req_tdata,   // v0_x, v0_y, v0_z, v1_x .. v2_z, zero pad
   input  logic                   req_tuser,   // first_of_batch
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,   // hit_distance, best_so_far, zero pad
   output logic                   rsp_tuser,   // hit
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int CW    = COORD_BITS;
   localparam int ENT_W = 9 * (CW + 1) + 1;
   localparam logic [CW-1:0] DIR_Z_RST = CW'(0) - (CW'(1) << FRAC_BITS);

   logic [CW-1:0]     origin_ff [3];
   logic [CW-1:0]     dir_ff    [3];
   logic [EPS_W-1:0]  eps_ff;
   logic [DIST_W-1:0] max_dist_ff;

   logic             f_valid, f_ready, b_valid, b_ready;
   logic [ENT_W-1:0] f_data, b_data;
   logic [DIST_W-1:0] hit_dist, best_dist;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= DIR_Z_RST;
         eps_ff       <= EPS_RST;
         max_dist_ff  <= MAX_DIST_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_ff[0] <= csr_data[CW-1:0];
            CSR_ORIGIN_Y: origin_ff[1] <= csr_data[CW-1:0];
            CSR_ORIGIN_Z: origin_ff[2] <= csr_data[CW-1:0];
            CSR_DIR_X:    dir_ff[0]    <= csr_data[CW-1:0];
            CSR_DIR_Y:    dir_ff[1]    <= csr_data[CW-1:0];
            CSR_DIR_Z:    dir_ff[2]    <= csr_data[CW-1:0];
            CSR_DET_EPS:  eps_ff       <= csr_data[EPS_W-1:0];
            CSR_MAX_DIST: max_dist_ff  <= csr_data[DIST_W-1:0];
            default:      eps_ff       <= eps_ff;
         endcase
      end
   end

   rtch_front #(
      .COORD_BITS (COORD_BITS),
      .REQ_W      (REQ_W),
      .ENT_W      (ENT_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .origin     ({origin_ff[2], origin_ff[1], origin_ff[0]}),
      .ent_valid  (f_valid),
      .ent_ready  (f_ready),
      .ent_data   (f_data)
   );

   rtch_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   rtch_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ENT_W      (ENT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (b_valid),
      .ent_ready (b_ready),
      .ent_data  (b_data),
      .dir       ({dir_ff[2], dir_ff[1], dir_ff[0]}),
      .det_eps   (eps_ff),
      .max_dist  (max_dist_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_dist  (hit_dist),
      .out_best  (best_dist)
   );

   assign rsp_tdata = {2'b00, best_dist, hit_dist};

   // A hit reports its distance as the new best
   a_hit_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (hit_dist == best_dist && hit_dist != '0))
      else $error("hit distance differs from best distance");

   // A miss reports zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (hit_dist == '0))
      else $error("miss carries a distance");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped while stalled");

endmodule

/* sim/rtch_hit_checker.sv */
// Checker for the ray/triangle closest-hit core: mirrors the registers, predicts and compares.
`timescale 1ns / 100ps
module rtch_hit_checker
   import rtch_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [287:0]           req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [63:0]            rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output int                     mismatch_count,
   output int                     pending_count,
   output int                     hit_count,
   output int                     result_count
);

   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] hit_dist;
      logic [30:0] best;
   } hit_result_type;

   // Register mirror and closest-distance state
   logic [31:0] ray_org [3];
   logic [31:0] ray_dir [3];
   logic [31:0] det_eps;
   logic [30:0] max_dist;
   logic [30:0] closest_dist;

   hit_result_type expected_hits [$];

   // Quantized distance of one triangle, zero when it misses before the distance bounds
   function automatic logic [30:0] triangle_dist(input logic [287:0] tri_bits);
      wide_type vtx [9];
      wide_type e1 [3], e2 [3], s [3], o [3], d [3], h [3], q [3];
      wide_type a, a_raw, lim, un, vn, tn, quo;
      logic [30:0] tq;
      tq = '0;
      for (int i = 0; i < 9; i++) begin
         vtx[i] = signed'(tri_bits[32*i +: 32]);
      end
      for (int i = 0; i < 3; i++) begin
         e1[i] = vtx[3+i] - vtx[i];
         e2[i] = vtx[6+i] - vtx[i];
         o[i]  = signed'(ray_org[i]);
         d[i]  = signed'(ray_dir[i]);
         s[i]  = o[i] - vtx[i];
      end
      h[0] = d[1] * e2[2] - d[2] * e2[1];
      h[1] = d[2] * e2[0] - d[0] * e2[2];
      h[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      a_raw = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
      un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
      vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      a = a_raw;
      // flip numerators with the determinant so that bounds are one-sided
      if (a_raw < 0) begin
         a  = -a_raw;
         un = -un;
         vn = -vn;
         tn = -tn;
      end
      lim = wide_type'({1'b0, det_eps}) <<< 16;
      if (a >= lim && a != 0 && un >= 0 && un <= a && vn >= 0 && un + vn <= a
          && tn > 0) begin
         quo = (tn <<< 16) / a;
         if (quo >= (wide_type'(1) <<< 31)) begin
            tq = '1;
         end else begin
            tq = quo[30:0];
         end
      end
      return tq;
   endfunction

   // Track transfers on all three channels
   always @(posedge clock) begin
      hit_result_type res;
      hit_result_type want;
      logic [30:0]    tq;
      if (reset) begin
         ray_org = '{32'd0, 32'd0, 32'd0};
         ray_dir = '{32'd0, 32'd0, 32'hFFFF_0000};
         det_eps = EPS_RST;
         max_dist = MAX_DIST_RST;
         closest_dist = MAX_DIST_RST;
         expected_hits.delete();
         mismatch_count = 0;
         hit_count = 0;
         result_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X: ray_org[0] = csr_data;
               CSR_ORIGIN_Y: ray_org[1] = csr_data;
               CSR_ORIGIN_Z: ray_org[2] = csr_data;
               CSR_DIR_X:    ray_dir[0] = csr_data;
               CSR_DIR_Y:    ray_dir[1] = csr_data;
               CSR_DIR_Z:    ray_dir[2] = csr_data;
               CSR_DET_EPS:  det_eps = csr_data;
               CSR_MAX_DIST: max_dist = csr_data[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) closest_dist = max_dist;
            tq = triangle_dist(req_tdata);
            res.hit = (tq != 0) && (tq < closest_dist);
            if (res.hit) closest_dist = tq;
            res.hit_dist = res.hit ? tq : 31'd0;
            res.best = closest_dist;
            expected_hits = {expected_hits, res};
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (rsp_tuser) hit_count++;
            if (expected_hits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transfer, tdata=%h", $realtime, rsp_tdata);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tuser !== want.hit || rsp_tdata[30:0] !== want.hit_dist ||
                   rsp_tdata[61:31] !== want.best || rsp_tdata[63:62] !== 2'b00) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch hit %0d/%0d dist %0d/%0d best %0d/%0d (exp/act)",
                              $realtime, want.hit, rsp_tuser, want.hit_dist, rsp_tdata[30:0],
                              want.best, rsp_tdata[61:31]);
               end
            end
         end
      end
      pending_count = expected_hits.size();
   end

endmodule

/* sim/tb_top.sv */
// Testbench top for the ray/triangle closest-hit core: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_top
   import rtch_pkg::*;
();

   localparam int ONE = 65536;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [287:0]           req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [63:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   int mismatch_count, pending_count, hit_count, result_count;
   int send_idle_pct, recv_stall_pct;
   bit hold_req;
   int tri_count, idle_cycles;
   int ray_o [3];
   int ray_d [3];
   logic [31:0] tri_c [9];

   ray_triangle_closest_hit_core uut (.*);

   rtch_hit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall, or one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 20000) begin
         $display("timeout: no transfer for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ORIGIN_X: ray_o[0] = value;
         CSR_ORIGIN_Y: ray_o[1] = value;
         CSR_ORIGIN_Z: ray_o[2] = value;
         CSR_DIR_X:    ray_d[0] = value;
         CSR_DIR_Y:    ray_d[1] = value;
         CSR_DIR_Z:    ray_d[2] = value;
         default: ;
      endcase
   endtask

   // Offer tri_c, wait for its transfer, then maybe go idle
   task automatic send_tri(input bit first);
      for (int i = 0; i < 9; i++) req_tdata[32*i +: 32] <= tri_c[i];
      req_tuser  <= first;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tri_count++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_scaled(input int x0, y0, z0, x1, y1, z1, x2, y2, z2, input bit first);
      tri_c = '{x0 * ONE, y0 * ONE, z0 * ONE, x1 * ONE, y1 * ONE, z1 * ONE,
                x2 * ONE, y2 * ONE, z2 * ONE};
      send_tri(first);
   endtask

   // Drop valid and let the core finish before touching registers
   task automatic drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Triangle around a point on the ray, mostly with the point inside
   task automatic make_tri();
      int p [3];
      int ea, eb, k;
      k = $urandom_range(1, 60);
      for (int i = 0; i < 3; i++) begin
         p[i] = ray_o[i] + ray_d[i] * k;
         ea = int'($urandom_range(0, 1 << 19)) - (1 << 18);
         eb = int'($urandom_range(0, 1 << 19)) - (1 << 18);
         tri_c[i]     = p[i] + ea;
         tri_c[3 + i] = p[i] + eb;
         tri_c[6 + i] = p[i] - ea - eb + int'($urandom_range(0, 2048)) - 1024;
      end
   endtask

   task automatic random_phase(input int n);
      int pick;
      for (int j = 0; j < n; j++) begin
         pick = $urandom_range(99);
         make_tri();
         if (pick < 15) begin
            for (int i = 0; i < 9; i++) tri_c[i] = $urandom;
         end else if (pick < 22) begin
            tri_c[$urandom_range(8)] = $urandom;
         end else if (pick < 27) begin
            for (int i = 3; i < 9; i++) tri_c[i] = tri_c[i % 3];
         end
         send_tri($urandom_range(4) == 0);
      end
   endtask

   task automatic random_ray();
      write_reg(CSR_ORIGIN_X, int'($urandom_range(0, 1 << 25)) - (1 << 24));
      write_reg(CSR_ORIGIN_Y, int'($urandom_range(0, 1 << 25)) - (1 << 24));
      write_reg(CSR_ORIGIN_Z, int'($urandom_range(0, 1 << 25)) - (1 << 24));
      write_reg(CSR_DIR_X, int'($urandom_range(0, 1 << 19)) - (1 << 18));
      write_reg(CSR_DIR_Y, int'($urandom_range(0, 1 << 19)) - (1 << 18));
      write_reg(CSR_DIR_Z, -int'($urandom_range(1, 1 << 18)));
      write_reg(CSR_DET_EPS, $urandom_range(0, 100000));
      write_reg(CSR_MAX_DIST, $urandom_range(10 * ONE, 80 * ONE));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_ORIGIN_X;
      csr_data = '0;
      hold_req = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      tri_count = 0;
      ray_o = '{0, 0, 0};
      ray_d = '{0, 0, -ONE};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed triangles against the default downward ray
      send_scaled(-1, -1, -5, 2, -1, -5, -1, 2, -5, 1);      // plain hit
      send_scaled(-1, -1, -10, 2, -1, -10, -1, 2, -10, 0);   // farther, no gain
      send_scaled(-1, -1, -3, -1, 2, -3, 2, -1, -3, 0);      // closer, other winding
      send_scaled(-1, -1, -3, 2, -1, -3, -1, 2, -3, 0);      // equal distance
      send_scaled(-1, -1, 5, 2, -1, 5, -1, 2, 5, 1);         // behind the origin
      send_scaled(0, 0, -2, 1, 0, -2, 0, 1, -2, 0);          // through a vertex
      send_scaled(-1, 0, -1, 1, 0, -1, 0, 1, -1, 0);         // along an edge
      send_scaled(0, 1, -1, 1, 1, -1, 0, 1, -2, 0);          // parallel plane
      send_scaled(3, 3, -3, 3, 3, -3, 3, 3, -3, 0);          // degenerate
      send_scaled(-1, -1, 0, 2, -1, 0, -1, 2, 0, 1);         // zero distance
      send_scaled(1, 1, -4, 2, 1, -4, 1, 2, -4, 0);          // just outside
      tri_c = '{-ONE, -ONE, -1, 2 * ONE, -ONE, -1, -ONE, 2 * ONE, -1};
      send_tri(1);                                           // smallest distance
      tri_c = '{default: 32'h7FFF_FFFF};
      send_tri(0);
      tri_c = '{default: 32'h8000_0000};
      send_tri(1);
      tri_c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      send_tri(0);
      send_scaled(-16000, -16000, -50, 32000, -16000, -50, -16000, 32000, -50, 1);
      drain();

      // Tiny direction: distance saturates
      write_reg(CSR_DIR_Z, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_DIST, 32'h7FFF_FFFF);
      write_reg(CSR_DET_EPS, 32'd0);
      send_scaled(-1, -1, -1, 2, -1, -1, -1, 2, -1, 1);
      send_scaled(-1, -1, -5, 2, -1, -5, -1, 2, -5, 0);
      drain();

      // Random rays under the idling mixes, with one long receiver hold-off
      random_ray();
      random_phase(90);
      drain();
      send_idle_pct = 60;
      random_ray();
      random_phase(90);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 60;
      random_ray();
      hold_req = 1'b1;
      random_phase(90);
      drain();
      send_idle_pct = 9;
      recv_stall_pct = 9;
      random_ray();
      random_phase(90);
      drain();

      // Extreme register settings
      write_reg(CSR_ORIGIN_X, 32'h7FFF_FFFF);
      write_reg(CSR_ORIGIN_Y, 32'h8000_0000);
      write_reg(CSR_ORIGIN_Z, 32'h7FFF_FFFF);
      write_reg(CSR_DIR_X, 32'h7FFF_FFFF);
      write_reg(CSR_DIR_Y, 32'h8000_0000);
      write_reg(CSR_DIR_Z, 32'h8000_0000);
      write_reg(CSR_DET_EPS, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_DIST, 32'd0);
      random_phase(40);
      drain();
      write_reg(CSR_ORIGIN_X, 32'd0);
      write_reg(CSR_ORIGIN_Y, 32'd0);
      write_reg(CSR_ORIGIN_Z, 32'd0);
      write_reg(CSR_DIR_X, 32'd0);
      write_reg(CSR_DIR_Y, 32'd0);
      write_reg(CSR_DIR_Z, 32'h8000_0000);
      write_reg(CSR_DET_EPS, 32'd0);
      write_reg(CSR_MAX_DIST, 32'h7FFF_FFFF);
      random_phase(40);
      drain();

      send_idle_pct = 30;
      recv_stall_pct = 30;
      random_ray();
      random_phase(90);
      drain();

      $display("Covered %0d triangles, %0d results, %0d hits, over default, random and",
               tri_count, result_count, hit_count);
      $display("extreme ray settings with sender gaps, receiver stalls and a long hold-off.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
